// File: hdl/sc1a_pkg.sv
package sc1a_pkg;

    // byte codes from the keyboard controller
    localparam logic [7:0] PREFIX_EXT0 = 8'hE0;
    localparam logic [7:0] PREFIX_EXT1 = 8'hE1;
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_CAPS   = 7'h3A;

    // key map size and letter range
    localparam int unsigned TAB_SIZE = 58;
    localparam logic [6:0] CHAR_LOW_A = 7'h61;
    localparam logic [6:0] CHAR_LOW_Z = 7'h7A;

    // us layout, unshifted
    localparam logic [6:0] PLAIN_TAB [0:TAB_SIZE-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    // us layout, shifted
    localparam logic [6:0] UPPER_TAB [0:TAB_SIZE-1] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    // keyboard modifier and prefix state
    typedef struct packed {
        logic shift;
        logic caps;
        logic prefix;
    } t_kbd_state;

    // decoder result for one beat
    typedef struct packed {
        logic       emit;
        logic [6:0] ascii_char;
    } t_dec_result;

endpackage

// File: hdl/sc1a_if.sv
// scan byte channel
interface sc1a_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;
    logic       from_aux;

    modport source (output valid, output scan_byte, output from_aux, input ready);
    modport sink   (input valid, input scan_byte, input from_aux, output ready);
endinterface

// ascii character channel
interface sc1a_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;

    modport source (output valid, output ascii_char, input ready);
    modport sink   (input valid, input ascii_char, output ready);
endinterface

// File: hdl/sc1a_decode.sv
module sc1a_decode
    import sc1a_pkg::*;
(
    input  logic [7:0]  i_scan_byte,
    input  logic        i_from_aux,
    input  t_kbd_state  i_state,
    output t_kbd_state  o_state,
    output t_dec_result o_result
);

    logic       released;
    logic [6:0] code;
    logic       in_tab;
    logic [5:0] tab_idx;
    logic [6:0] lower;
    logic [6:0] upper;
    logic       is_letter;
    logic       use_upper;

    // split the byte and look up both tables
    assign released  = i_scan_byte[7];
    assign code      = i_scan_byte[6:0];
    assign in_tab    = (code < 7'(TAB_SIZE));
    assign tab_idx   = code[5:0];
    assign lower     = in_tab ? PLAIN_TAB[tab_idx] : 7'h00;
    assign upper     = in_tab ? UPPER_TAB[tab_idx] : 7'h00;
    assign is_letter = (lower >= CHAR_LOW_A) && (lower <= CHAR_LOW_Z);
    assign use_upper = is_letter ? (i_state.shift ^ i_state.caps) : i_state.shift;

    // state update and result selection
    always_comb begin
        o_state             = i_state;
        o_result.emit       = 1'b0;
        o_result.ascii_char = use_upper ? upper : lower;
        if (i_from_aux) begin
            o_state = i_state;
        end else if (i_scan_byte == PREFIX_EXT0 || i_scan_byte == PREFIX_EXT1) begin
            o_state.prefix = 1'b1;
        end else if (i_state.prefix) begin
            o_state.prefix = 1'b0;
        end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            o_state.shift = ~released;
        end else if (!released && code == CODE_CAPS) begin
            o_state.caps = ~i_state.caps;
        end else if (!released && lower != 7'h00) begin
            o_result.emit = 1'b1;
        end
    end

endmodule

// File: hdl/scancode_set1_to_ascii.sv
// Scan code set 1 to ASCII translator, US layout. Each input beat carries one
// byte from the keyboard controller and a flag for the mouse port; mouse bytes
// are dropped, 0xE0/0xE1 prefixes swallow the following byte, shift and caps
// lock are tracked, and each mapped key press gives one 7-bit ASCII beat.
// Releases, modifiers and unmapped keys give no output beat. A byte is taken
// into an input register, decoded and reflected in the output register, and
// one byte is accepted every cycle while the output is not held back; the
// output register lets a new byte in while a character waits.
module scancode_set1_to_ascii
    import sc1a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sc1a_in_if.sink           i_in,
    sc1a_out_if.source        o_out
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_aux;
    t_kbd_state  r_state;
    t_kbd_state  n_state;
    logic        r_out_valid;
    logic [6:0]  r_out_char;
    logic        n_out_valid;
    logic        adv;
    t_kbd_state  dec_state;
    t_dec_result dec_result;

    // input stage moves on whenever the output register can take a beat
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.scan_byte;
            r_aux  <= i_in.from_aux;
        end
    end

    sc1a_decode u_decode (
        .i_scan_byte (r_byte),
        .i_from_aux  (r_aux),
        .i_state     (r_state),
        .o_state     (dec_state),
        .o_result    (dec_result)
    );

    // next state and output valid
    always_comb begin
        n_state     = adv ? dec_state : r_state;
        n_out_valid = r_out_valid && !o_out.ready;
        if (adv && dec_result.emit) begin
            n_out_valid = 1'b1;
        end
    end

    // keyboard state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (adv && dec_result.emit) begin
            r_out_char <= dec_result.ascii_char;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_out_char;

    // mouse bytes leave the keyboard state alone
    a_aux_no_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_aux |=> r_state == $past(r_state))
        else $error("mouse byte changed keyboard state");

    // a prefix byte from the keyboard always arms the prefix flag
    a_prefix_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_aux && (r_byte == PREFIX_EXT0 || r_byte == PREFIX_EXT1)
        |=> r_state.prefix)
        else $error("prefix byte did not arm prefix flag");

    // a byte behind a prefix never produces a character
    a_prefix_swallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_aux && r_state.prefix && r_byte != PREFIX_EXT0
        && r_byte != PREFIX_EXT1 |-> !dec_result.emit)
        else $error("byte after prefix produced output");

    // a delivered character is never zero
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_char != 7'h00)
        else $error("zero character on output");

    // a stalled input register keeps its byte
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_byte) && $stable(r_aux))
        else $error("input register lost a stalled byte");

endmodule

// File: test/tb_scancode_set1_to_ascii.sv
`timescale 1ns / 100ps

module tb_scancode_set1_to_ascii;
    import sc1a_pkg::*;

    // one byte from the keyboard controller
    typedef struct packed {
        logic [7:0] scan_byte;
        logic       from_aux;
    } t_scan_beat;

    localparam logic [6:0] KEY_A     = 7'h1E;
    localparam logic [6:0] KEY_1     = 7'h02;
    localparam logic [6:0] KEY_CTRL  = 7'h1D;
    localparam logic [6:0] KEY_SLASH = 7'h35;
    localparam logic [6:0] KEY_SPACE = 7'h39;
    localparam logic [6:0] KEY_Q     = 7'h10;
    localparam logic [6:0] KEY_P     = 7'h19;
    localparam logic [6:0] KEY_TOP   = 7'h7F;
    localparam logic [6:0] LETTER_FIRST = 7'h61;
    localparam logic [6:0] LETTER_LAST  = 7'h7A;
    localparam int         PHASE_BEATS  = 375;

    // us key map, plain and with shift
    localparam logic [6:0] MAP_PLAIN [0:TAB_SIZE-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };
    localparam logic [6:0] MAP_SHIFTED [0:TAB_SIZE-1] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sc1a_in_if  u_scan_if ();
    sc1a_out_if u_char_if ();

    scancode_set1_to_ascii u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_scan_if),
        .o_out   (u_char_if)
    );

    t_scan_beat scan_backlog [$];
    logic [6:0] expected_chars [$];
    t_scan_beat next_beat;
    logic [6:0] want_char;

    // keyboard state as the translator should track it
    logic kbd_shift;
    logic kbd_caps;
    logic kbd_prefix;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic send_hold    = 1'b0;
    logic recv_hold    = 1'b0;
    int live_beats     = 0;
    int error_count    = 0;

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (error_count < 50) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    // expected translation of one accepted byte, updates the key state
    function automatic void translate_key(input logic [7:0] raw, input logic aux);
        logic       released;
        logic [6:0] code;
        logic [6:0] plain;
        logic       upper;
        if (aux) return;
        if (raw == PREFIX_EXT0 || raw == PREFIX_EXT1) begin
            kbd_prefix = 1'b1;
            return;
        end
        released = raw[7];
        code     = raw[6:0];
        if (kbd_prefix) begin
            kbd_prefix = 1'b0;
            return;
        end
        if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            kbd_shift = !released;
            return;
        end
        if (!released && code == CODE_CAPS) begin
            kbd_caps = !kbd_caps;
            return;
        end
        if (released || code >= TAB_SIZE) return;
        plain = MAP_PLAIN[code[5:0]];
        if (plain == 7'h00) return;
        if (plain >= LETTER_FIRST && plain <= LETTER_LAST) begin
            upper = kbd_shift ^ kbd_caps;
        end else begin
            upper = kbd_shift;
        end
        expected_chars.push_back(upper ? MAP_SHIFTED[code[5:0]] : plain);
    endfunction

    task automatic add_beat(input logic [7:0] raw, input logic aux);
        t_scan_beat b;
        b.scan_byte = raw;
        b.from_aux  = aux;
        scan_backlog.push_back(b);
        if (!aux) live_beats++;
    endtask

    // mostly typing-like sequences, some prefixes, mouse bytes and noise
    task automatic add_random_sequence();
        int unsigned pick;
        int unsigned taps;
        logic [6:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            code = 7'($urandom_range(0, TAB_SIZE - 1));
            add_beat({1'b0, code}, 1'b0);
            if ($urandom_range(0, 3) != 0) add_beat({1'b1, code}, 1'b0);
        end else if (pick < 62) begin
            code = $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
            add_beat({1'b0, code}, 1'b0);
            taps = $urandom_range(1, 4);
            repeat (taps) begin
                code = 7'($urandom_range(0, TAB_SIZE - 1));
                add_beat({1'b0, code}, 1'b0);
                add_beat({1'b1, code}, 1'b0);
            end
            code = $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
            add_beat({1'b1, code}, 1'b0);
        end else if (pick < 70) begin
            add_beat({1'b0, CODE_CAPS}, 1'b0);
            if ($urandom_range(0, 1) != 0) add_beat({1'b1, CODE_CAPS}, 1'b0);
        end else if (pick < 78) begin
            add_beat($urandom_range(0, 1) ? PREFIX_EXT0 : PREFIX_EXT1, 1'b0);
            if ($urandom_range(0, 3) == 0) add_beat(PREFIX_EXT1, 1'b0);
            add_beat(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 86) begin
            add_beat(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            add_beat(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic fill_random(input int beats);
        int target;
        target = live_beats + beats;
        while (live_beats < target) add_random_sequence();
    endtask

    task automatic wait_backlog_empty();
        while (scan_backlog.size() != 0 || u_scan_if.valid) @(negedge i_clk);
    endtask

    // scan byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_scan_if.valid <= 1'b0;
        end else begin
            if (u_scan_if.valid && u_scan_if.ready) begin
                translate_key(u_scan_if.scan_byte, u_scan_if.from_aux);
            end
            if (u_scan_if.valid && !u_scan_if.ready) begin
                // beat still waiting, keep it on the bus
            end else if (!send_hold && scan_backlog.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                next_beat = scan_backlog.pop_front();
                u_scan_if.valid     <= 1'b1;
                u_scan_if.scan_byte <= next_beat.scan_byte;
                u_scan_if.from_aux  <= next_beat.from_aux;
            end else begin
                u_scan_if.valid <= 1'b0;
            end
        end
    end

    // ascii character monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_char_if.ready <= 1'b0;
        end else begin
            if (u_char_if.valid && u_char_if.ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h",
                                              u_char_if.ascii_char));
                end else begin
                    want_char = expected_chars.pop_front();
                    if (u_char_if.ascii_char !== want_char) begin
                        report_mismatch($sformatf("ascii_char 0x%02h, want 0x%02h",
                                                  u_char_if.ascii_char, want_char));
                    end
                end
            end
            if (recv_hold) begin
                u_char_if.ready <= 1'b0;
            end else begin
                u_char_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("scancode_set1_to_ascii verification failed");
        $finish;
    end

    initial begin
        int drain_cycles;
        logic [6:0] code;
        i_rst_n             = 1'b0;
        u_scan_if.valid     = 1'b0;
        u_scan_if.scan_byte = 8'h00;
        u_scan_if.from_aux  = 1'b0;
        u_char_if.ready     = 1'b0;
        kbd_shift           = 1'b0;
        kbd_caps            = 1'b0;
        kbd_prefix          = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, modifiers, prefixes, mouse bytes
        add_beat(8'h00, 1'b0);
        add_beat({1'b0, KEY_A}, 1'b0);
        add_beat(8'hFF, 1'b1);
        add_beat(PREFIX_EXT0, 1'b1);
        add_beat({1'b0, KEY_SPACE}, 1'b0);
        add_beat({1'b0, KEY_TOP}, 1'b0);
        add_beat({1'b1, KEY_TOP}, 1'b0);
        add_beat({1'b0, CODE_LSHIFT}, 1'b0);
        add_beat({1'b0, KEY_A}, 1'b0);
        add_beat({1'b0, KEY_1}, 1'b0);
        add_beat({1'b0, CODE_CAPS}, 1'b0);
        add_beat({1'b0, KEY_A}, 1'b0);
        add_beat({1'b0, KEY_1}, 1'b0);
        add_beat({1'b1, CODE_RSHIFT}, 1'b0);
        add_beat({1'b0, KEY_A}, 1'b0);
        add_beat({1'b0, KEY_1}, 1'b0);
        add_beat({1'b1, CODE_CAPS}, 1'b0);
        add_beat(PREFIX_EXT0, 1'b0);
        add_beat({1'b0, CODE_LSHIFT}, 1'b0);
        add_beat({1'b0, KEY_A}, 1'b0);
        add_beat(PREFIX_EXT1, 1'b0);
        add_beat(PREFIX_EXT0, 1'b0);
        add_beat({1'b0, KEY_A}, 1'b1);
        add_beat({1'b0, CODE_CAPS}, 1'b0);
        add_beat({1'b0, KEY_CTRL}, 1'b0);
        add_beat({1'b0, CODE_CAPS}, 1'b0);
        add_beat({1'b0, KEY_SLASH}, 1'b0);
        wait_backlog_empty();

        // no idling
        fill_random(PHASE_BEATS);
        wait_backlog_empty();

        // receiver holds off while letters keep coming, block backs up
        fork
            begin
                recv_hold = 1'b1;
                repeat (250) @(negedge i_clk);
                recv_hold = 1'b0;
            end
        join_none
        repeat (30) begin
            code = 7'($urandom_range(KEY_Q, KEY_P));
            add_beat({1'b0, code}, 1'b0);
        end
        @(negedge i_clk);
        while (recv_hold) @(negedge i_clk);
        wait_backlog_empty();

        // sender idles
        send_idle_pct  = 70;
        recv_stall_pct = 0;
        fill_random(PHASE_BEATS);
        wait_backlog_empty();

        // receiver stalls, with one pause of the sender until all chars are out
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        fill_random(PHASE_BEATS);
        while (scan_backlog.size() > 200) @(negedge i_clk);
        send_hold = 1'b1;
        while (u_scan_if.valid || expected_chars.size() != 0) @(negedge i_clk);
        send_hold = 1'b0;
        wait_backlog_empty();

        // both sides idle
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        fill_random(PHASE_BEATS);
        wait_backlog_empty();

        // drain and settle
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_cycles = 0;
        while (expected_chars.size() != 0 && drain_cycles < 1000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(negedge i_clk);
        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d chars never came out", expected_chars.size()));
        end

        if (error_count == 0) begin
            $display("scancode_set1_to_ascii verification clean");
        end else begin
            $display("scancode_set1_to_ascii verification failed");
        end
        $finish;
    end

endmodule
